[rtl/ttcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared constants, codes and controller/datapath interface types for the
// text terminal cell buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

  // store geometry
  localparam int DEPTH    = 4096;
  localparam int AW       = 12;
  localparam int LW       = 13;
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;

  // attribute written by the power-up clearing pass
  localparam logic [7:0] BLANK_ATTR_RST = 8'd7;

  // character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NUL       = 8'd0;

  // request function codes
  localparam logic [1:0] FN_PUT   = 2'd0;
  localparam logic [1:0] FN_CLEAR = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_COLS       = 3'd0;
  localparam logic [2:0] REG_ROWS       = 3'd1;
  localparam logic [2:0] REG_TEXT_ATTR  = 3'd2;
  localparam logic [2:0] REG_BLANK_ATTR = 3'd3;
  localparam logic [2:0] REG_ORIGIN_COL = 3'd4;
  localparam logic [2:0] REG_ORIGIN_ROW = 3'd5;

  // datapath operation codes
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_ACCEPT     = 5'd1;
  localparam logic [4:0] OP_INIT_STEP  = 5'd2;
  localparam logic [4:0] OP_TGT_NL     = 5'd3;
  localparam logic [4:0] OP_TGT_INC    = 5'd4;
  localparam logic [4:0] OP_DIV_CUR    = 5'd5;
  localparam logic [4:0] OP_TGT_ROW    = 5'd6;
  localparam logic [4:0] OP_BACKSPACE  = 5'd7;
  localparam logic [4:0] OP_COMMIT     = 5'd8;
  localparam logic [4:0] OP_SCROLL_GO  = 5'd9;
  localparam logic [4:0] OP_COPY_RD    = 5'd10;
  localparam logic [4:0] OP_COPY_WR    = 5'd11;
  localparam logic [4:0] OP_BLANK_GO   = 5'd12;
  localparam logic [4:0] OP_BLANK_STEP = 5'd13;
  localparam logic [4:0] OP_SCROLL_END = 5'd14;
  localparam logic [4:0] OP_CLEAR_GO   = 5'd15;
  localparam logic [4:0] OP_CLEAR_STEP = 5'd16;
  localparam logic [4:0] OP_READ_RD    = 5'd17;
  localparam logic [4:0] OP_READ_CAP   = 5'd18;
  localparam logic [4:0] OP_OUT_LOAD   = 5'd19;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_nl;
    logic       is_cr;
    logic       is_bs;
    logic       is_tab;
    logic       tgt_ge_len;
    logic       copy_done;
    logic       cell_last;
    logic       init_last;
    logic       div_valid;
    logic       out_busy;
  } sts_t;

endpackage

[rtl/ttcb_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_div
// Restoring divider, one quotient bit per cycle: cursor by column count.
// ----------------------------------------------------------------------------
module ttcb_div import ttcb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [7:0]    divisor,
  output logic [AW-1:0] quo,
  output logic [7:0]    rem,
  output logic          valid
);

  logic [AW-1:0] dq_r, dq_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          valid_r, valid_nxt;
  logic [8:0]    shifted;
  logic [9:0]    trial;

  // one shift and trial subtract per cycle
  always_comb begin
    shifted   = {rem_r, dq_r[AW-1]};
    trial     = {1'b0, shifted} - {2'b0, divisor};
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    valid_nxt = valid_r;
    if (start) begin
      dq_nxt    = dividend;
      rem_nxt   = 8'd0;
      cnt_nxt   = 4'(AW);
      busy_nxt  = 1'b1;
      valid_nxt = 1'b0;
    end else if (busy_r) begin
      if (!trial[9]) begin
        rem_nxt = trial[7:0];
        dq_nxt  = {dq_r[AW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[7:0];
        dq_nxt  = {dq_r[AW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt  = 1'b0;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign quo   = dq_r;
  assign rem   = rem_r;
  assign valid = valid_r;

endmodule

[rtl/ttcb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_dp
// Datapath: configuration registers, cell store, cursor, client mark,
// sweep counter, divider and result register.
// ----------------------------------------------------------------------------
module ttcb_dp import ttcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_char_code,
  input  logic              in_from_server,
  input  logic [11:0]       in_cell_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_cell_char,
  output logic [7:0]        out_cell_attr,
  output logic [11:0]       out_cursor_index,
  output logic [7:0]        out_cursor_col,
  output logic [7:0]        out_cursor_row,
  output logic signed [12:0] out_client_mark_out
);

  // configuration registers
  logic [7:0] cols_cfg_r, rows_cfg_full;
  logic [5:0] rows_cfg_r;
  logic [7:0] text_attr_r, blank_attr_r;
  logic [6:0] origin_col_r, origin_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r   <= 8'd80;
      rows_cfg_r   <= 6'd25;
      text_attr_r  <= 8'd7;
      blank_attr_r <= 8'd7;
      origin_col_r <= 7'd0;
      origin_row_r <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLS:       cols_cfg_r   <= cfg_wdata;
        REG_ROWS:       rows_cfg_r   <= cfg_wdata[5:0];
        REG_TEXT_ATTR:  text_attr_r  <= cfg_wdata;
        REG_BLANK_ATTR: blank_attr_r <= cfg_wdata;
        REG_ORIGIN_COL: origin_col_r <= cfg_wdata[6:0];
        REG_ORIGIN_ROW: origin_row_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // saturated geometry
  logic [7:0]  cols_eff;
  logic [5:0]  rows_eff;
  logic [13:0] len_prod;

  assign rows_cfg_full = {2'b0, rows_cfg_r};
  always_comb begin
    cols_eff = cols_cfg_r;
    if (cols_cfg_r == 8'd0) cols_eff = 8'd1;
    else if (cols_cfg_r > 8'(MAX_COLS)) cols_eff = 8'(MAX_COLS);
    rows_eff = rows_cfg_r;
    if (rows_cfg_r == 6'd0) rows_eff = 6'd1;
    else if (rows_cfg_full > 8'(MAX_ROWS)) rows_eff = 6'(MAX_ROWS);
    len_prod = {6'b0, cols_eff} * {8'b0, rows_eff};
  end

  // request and working registers
  logic [1:0]        func_r;
  logic [7:0]        ch_r;
  logic              server_r;
  logic [AW-1:0]     idx_r;
  logic [7:0]        cols_r;
  logic [LW-1:0]     len_r;
  logic [AW-1:0]     cur_r;
  logic signed [12:0] mark_r;
  logic [LW-1:0]     tgt_r;
  logic [LW-1:0]     cnt_r;
  logic [7:0]        rc_r, ra_r;

  logic              client;
  logic [LW-1:0]     cur_ext;
  logic [LW-1:0]     row_base;
  logic signed [13:0] mark_sub;
  logic signed [12:0] mark_scrolled;
  logic              bs_ok;
  logic [13:0]       copy_end;

  // divider
  logic [AW-1:0] div_quo;
  logic [7:0]    div_rem;
  logic          div_valid;

  ttcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV_CUR),
    .dividend (cur_r),
    .divisor  (cols_r),
    .quo      (div_quo),
    .rem      (div_rem),
    .valid    (div_valid)
  );

  assign client   = !server_r;
  assign cur_ext  = {1'b0, cur_r};
  assign row_base = len_r - {5'b0, cols_r};
  assign mark_sub = {mark_r[12], mark_r} - $signed({6'b0, cols_r});
  assign mark_scrolled = (mark_sub < 0) ? -13'sd1 : mark_sub[12:0];
  // server may only erase a cell at or past the client mark (signed compare)
  assign bs_ok = (cur_r != '0) && (cur_ext < len_r) &&
                 (client || ($signed({1'b0, cur_ext}) > $signed({mark_r[12], mark_r})));
  assign copy_end = {1'b0, cnt_r} + {6'b0, cols_r};

  // cell store: one write and one registered read per cycle
  logic [7:0]    char_mem [DEPTH];
  logic [7:0]    attr_mem [DEPTH];
  logic          we_char, we_attr;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd_char, wd_attr;
  logic [7:0]    rd_char, rd_attr;

  always_comb begin
    we_char = 1'b0;
    we_attr = 1'b0;
    wa      = cnt_r[AW-1:0];
    wd_char = CH_NUL;
    wd_attr = blank_attr_r;
    ra      = idx_r;
    case (cmd.op)
      OP_INIT_STEP: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        wd_attr = BLANK_ATTR_RST;
      end
      OP_TGT_INC: begin
        we_char = cur_ext < len_r;
        we_attr = cur_ext < len_r;
        wa      = cur_r;
        wd_char = ch_r;
        wd_attr = text_attr_r;
      end
      OP_BACKSPACE: begin
        we_char = bs_ok;
        wa      = cur_r - AW'(1);
      end
      OP_COPY_RD: ra = copy_end[AW-1:0];
      OP_COPY_WR: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        wd_char = rd_char;
        wd_attr = rd_attr;
      end
      OP_BLANK_STEP, OP_CLEAR_STEP: begin
        we_char = 1'b1;
        we_attr = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_char) char_mem[wa] <= wd_char;
    if (we_attr) attr_mem[wa] <= wd_attr;
    rd_char <= char_mem[ra];
    rd_attr <= attr_mem[ra];
  end

  // cursor, mark and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      mark_r <= -13'sd1;
      cnt_r  <= '0;
    end else begin
      case (cmd.op)
        OP_INIT_STEP, OP_COPY_WR, OP_BLANK_STEP, OP_CLEAR_STEP:
          cnt_r <= cnt_r + LW'(1);
        OP_BACKSPACE: if (bs_ok) begin
          cur_r <= cur_r - AW'(1);
          if (client) mark_r <= $signed({1'b0, cur_r - AW'(1)});
        end
        OP_COMMIT: begin
          cur_r <= tgt_r[AW-1:0];
          if (client) mark_r <= $signed({1'b0, tgt_r[AW-1:0]});
        end
        OP_SCROLL_GO: cnt_r <= '0;
        OP_BLANK_GO:  cnt_r <= row_base;
        OP_SCROLL_END: begin
          cur_r <= row_base[AW-1:0];
          if (client) mark_r <= $signed({1'b0, row_base[AW-1:0]});
          else        mark_r <= mark_scrolled;
        end
        OP_CLEAR_GO: begin
          cur_r <= '0;
          cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // request capture, target and read result
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        func_r   <= in_func;
        ch_r     <= in_char_code;
        server_r <= in_from_server;
        idx_r    <= in_cell_index;
        cols_r   <= cols_eff;
        len_r    <= len_prod[LW-1:0];
        rc_r     <= 8'd0;
        ra_r     <= 8'd0;
      end
      OP_TGT_NL:  tgt_r <= cur_ext + {5'b0, cols_r};
      OP_TGT_INC: tgt_r <= cur_ext + LW'(1);
      OP_TGT_ROW: tgt_r <= cur_ext - {5'b0, div_rem};
      OP_READ_CAP: if ({1'b0, idx_r} < len_r) begin
        rc_r <= rd_char;
        ra_r <= rd_attr;
      end
      default: ;
    endcase
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == OP_OUT_LOAD) begin
      out_cell_char       <= rc_r;
      out_cell_attr       <= ra_r;
      out_cursor_index    <= cur_r;
      out_cursor_col      <= {1'b0, origin_col_r} + div_rem;
      out_cursor_row      <= {1'b0, origin_row_r} + div_quo[7:0];
      out_client_mark_out <= mark_r;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  always_comb begin
    sts.func       = func_r;
    sts.is_nl      = ch_r == CH_NEWLINE;
    sts.is_cr      = ch_r == CH_RETURN;
    sts.is_bs      = ch_r == CH_BACKSPACE;
    sts.is_tab     = ch_r == CH_TAB;
    sts.tgt_ge_len = tgt_r >= len_r;
    sts.copy_done  = copy_end >= {1'b0, len_r};
    sts.cell_last  = cnt_r == len_r - LW'(1);
    sts.init_last  = cnt_r == LW'(DEPTH - 1);
    sts.div_valid  = div_valid;
    sts.out_busy   = out_valid_r && !out_ready;
  end

endmodule

[rtl/ttcb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Controller: sequences decode, cursor moves, scroll, clear, read and
// result hand-off, one datapath operation per cycle outside wait states.
// ----------------------------------------------------------------------------
module ttcb_ctrl import ttcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_MOVE     = 4'd4;
  localparam logic [3:0] S_ROW_DIV  = 4'd5;
  localparam logic [3:0] S_COPY_RD  = 4'd6;
  localparam logic [3:0] S_COPY_WR  = 4'd7;
  localparam logic [3:0] S_BLANK    = 4'd8;
  localparam logic [3:0] S_SCR_END  = 4'd9;
  localparam logic [3:0] S_CLEAR    = 4'd10;
  localparam logic [3:0] S_READ_CAP = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;
  localparam logic [3:0] S_FIN_WAIT = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       row_r, row_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT_STEP;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_ACCEPT;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        row_nxt   = 1'b0;
        state_nxt = S_FIN;
        case (sts.func)
          FN_PUT: begin
            if (sts.is_nl) begin
              cmd.op    = OP_TGT_NL;
              row_nxt   = 1'b1;
              state_nxt = S_MOVE;
            end else if (sts.is_cr) begin
              cmd.op    = OP_DIV_CUR;
              state_nxt = S_DIV_WAIT;
            end else if (sts.is_bs) begin
              cmd.op = OP_BACKSPACE;
            end else if (!sts.is_tab) begin
              cmd.op    = OP_TGT_INC;
              state_nxt = S_MOVE;
            end
          end
          FN_CLEAR: begin
            cmd.op    = OP_CLEAR_GO;
            state_nxt = S_CLEAR;
          end
          FN_READ: begin
            cmd.op    = OP_READ_RD;
            state_nxt = S_READ_CAP;
          end
          default: ;
        endcase
      end
      // row start of the cursor as the next target
      S_DIV_WAIT: if (sts.div_valid) begin
        cmd.op    = OP_TGT_ROW;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (sts.tgt_ge_len) begin
          cmd.op    = OP_SCROLL_GO;
          state_nxt = S_COPY_RD;
        end else begin
          cmd.op    = OP_COMMIT;
          state_nxt = row_r ? S_ROW_DIV : S_FIN;
          row_nxt   = 1'b0;
        end
      end
      S_ROW_DIV: begin
        cmd.op    = OP_DIV_CUR;
        state_nxt = S_DIV_WAIT;
      end
      // scroll: move each row up, then blank the last row
      S_COPY_RD: begin
        if (sts.copy_done) begin
          cmd.op    = OP_BLANK_GO;
          state_nxt = S_BLANK;
        end else begin
          cmd.op    = OP_COPY_RD;
          state_nxt = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd.op    = OP_COPY_WR;
        state_nxt = S_COPY_RD;
      end
      S_BLANK: begin
        cmd.op = OP_BLANK_STEP;
        if (sts.cell_last) state_nxt = S_SCR_END;
      end
      S_SCR_END: begin
        cmd.op    = OP_SCROLL_END;
        state_nxt = row_r ? S_ROW_DIV : S_FIN;
        row_nxt   = 1'b0;
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR_STEP;
        if (sts.cell_last) state_nxt = S_FIN;
      end
      S_READ_CAP: begin
        cmd.op    = OP_READ_CAP;
        state_nxt = S_FIN;
      end
      // screen coordinates of the final cursor
      S_FIN: begin
        cmd.op    = OP_DIV_CUR;
        state_nxt = S_FIN_WAIT;
      end
      S_FIN_WAIT: if (sts.div_valid) state_nxt = S_OUT;
      S_OUT: if (!sts.out_busy) begin
        cmd.op    = OP_OUT_LOAD;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      row_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

[rtl/text_terminal_cell_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer
// Text-mode terminal engine: character/attribute grid with cursor, client
// mark, scrolling, clear and cell read.
// ----------------------------------------------------------------------------
//
//   channel   signals                                  handshake
//   in        in_func, in_char_code, in_from_server,   in_valid / in_ready
//             in_cell_index
//   out       out_cell_char ... out_client_mark_out    out_valid / out_ready
//   cfg       cfg_index, cfg_wdata                     cfg_we (no wait)
//
// For a plain put, read or tab, the cursor divider for the screen
// coordinates takes most of the time; newline or return add one more
// divide. A scroll moves L-cols cells up and blanks cols cells, a clear
// blanks L cells, one store access per cycle (L = cols*rows). After
// reset a clearing pass over all 4096 cells runs before the first request.
// A stalled result sits in the output register while the next request is
// taken and worked on.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer import ttcb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_char_code,
  input  logic               in_from_server,
  input  logic [11:0]        in_cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_cell_char,
  output logic [7:0]         out_cell_attr,
  output logic [11:0]        out_cursor_index,
  output logic [7:0]         out_cursor_col,
  output logic [7:0]         out_cursor_row,
  output logic signed [12:0] out_client_mark_out
);

  cmd_t cmd;
  sts_t sts;

  ttcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttcb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_from_server      (in_from_server),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_char       (out_cell_char),
    .out_cell_attr       (out_cell_attr),
    .out_cursor_index    (out_cursor_index),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_client_mark_out (out_client_mark_out)
  );

  // a request is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in work");

  // result register is only loaded when free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT_LOAD |-> !out_valid || out_ready)
    else $error("result overwritten while stalled");

  // client mark never below minus one
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_client_mark_out >= -13'sd1)
    else $error("client mark out of range");

endmodule

[tb/sv/text_terminal_cell_buffer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_test
// Self-checking bench for the terminal cell buffer. Puts, clears, reads and
// unused codes are pushed through under several box geometries. A local
// terminal model predicts each result, and results are checked in order.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer_test;
  import ttcb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 3000;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  ch;
    logic        srv;
    logic [11:0] idx;
  } term_req_t;

  typedef struct {
    logic [7:0]  cchar;
    logic [7:0]  cattr;
    logic [11:0] cidx;
    logic [7:0]  ccol;
    logic [7:0]  crow;
    logic [12:0] mark;
  } term_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_func;
  logic [7:0] in_char_code;
  logic in_from_server;
  logic [11:0] in_cell_index;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_attr;
  logic [11:0] out_cursor_index;
  logic [7:0] out_cursor_col;
  logic [7:0] out_cursor_row;
  logic signed [12:0] out_client_mark_out;

  text_terminal_cell_buffer uut (.*);

  // model state
  logic [7:0] grid_char [DEPTH];
  logic [7:0] grid_attr [DEPTH];
  int cursor_m;
  int mark_m;
  int cols_r, rows_r, tattr_r, battr_r, ocol_r, orow_r;

  term_req_t pending_q[$];
  term_rsp_t cursor_report_q[$];
  int errors;
  int cycles;
  bit req_taken;
  int burst_left, gap_left;
  int hold_asks, hold_served, hold_cnt, stall_mode, mode_left;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int box_cols();
    return (cols_r < 1) ? 1 : (cols_r > MAX_COLS) ? MAX_COLS : cols_r;
  endfunction

  function automatic int box_rows();
    return (rows_r < 1) ? 1 : (rows_r > MAX_ROWS) ? MAX_ROWS : rows_r;
  endfunction

  // scroll up one row, blank the last row, pull the mark up
  function automatic void grid_scroll(int cols, int len);
    for (int i = 0; i + cols < len && i + cols < DEPTH; i++) begin
      grid_char[i] = grid_char[i + cols];
      grid_attr[i] = grid_attr[i + cols];
    end
    for (int i = 0; i < cols && i < len; i++) begin
      grid_char[len - 1 - i] = CH_NUL;
      grid_attr[len - 1 - i] = battr_r[7:0];
    end
    mark_m -= cols;
    if (mark_m < 0) mark_m = -1;
  endfunction

  function automatic void cursor_move(int p, bit client, int cols, int len);
    if (p >= len) begin
      grid_scroll(cols, len);
      p = len - cols;
    end
    cursor_m = p & 12'hfff;
    if (client) mark_m = cursor_m;
  endfunction

  // expected result of one request, updating the model
  function automatic term_rsp_t terminal_step(term_req_t r);
    term_rsp_t e;
    int cols, len;
    bit client;
    cols = box_cols();
    len = cols * box_rows();
    client = !r.srv;
    e.cchar = '0;
    e.cattr = '0;
    if (r.func == FN_PUT) begin
      if (r.ch == CH_NEWLINE) begin
        cursor_move(cursor_m + cols, client, cols, len);
        cursor_move((cursor_m / cols) * cols, client, cols, len);
      end else if (r.ch == CH_RETURN) begin
        cursor_move((cursor_m / cols) * cols, client, cols, len);
      end else if (r.ch == CH_BACKSPACE) begin
        if (cursor_m > 0 && cursor_m < len && (client || cursor_m > mark_m)) begin
          cursor_move(cursor_m - 1, client, cols, len);
          if (cursor_m < len) grid_char[cursor_m] = CH_NUL;
        end
      end else if (r.ch != CH_TAB) begin
        if (cursor_m < len) begin
          grid_char[cursor_m] = r.ch;
          grid_attr[cursor_m] = tattr_r[7:0];
        end
        cursor_move(cursor_m + 1, client, cols, len);
      end
    end else if (r.func == FN_CLEAR) begin
      cursor_m = 0;
      for (int i = 0; i < len; i++) begin
        grid_char[i] = CH_NUL;
        grid_attr[i] = battr_r[7:0];
      end
    end else if (r.func == FN_READ) begin
      if (r.idx < len) begin
        e.cchar = grid_char[r.idx];
        e.cattr = grid_attr[r.idx];
      end
    end
    e.cidx = cursor_m[11:0];
    e.ccol = 8'(ocol_r + cursor_m % cols);
    e.crow = 8'(orow_r + cursor_m / cols);
    e.mark = 13'(mark_m);
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[7:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLS:       cols_r = val & 8'hff;
      REG_ROWS:       rows_r = val & 6'h3f;
      REG_TEXT_ATTR:  tattr_r = val & 8'hff;
      REG_BLANK_ATTR: battr_r = val & 8'hff;
      REG_ORIGIN_COL: ocol_r = val & 7'h7f;
      REG_ORIGIN_ROW: orow_r = val & 7'h7f;
      default: ;
    endcase
  endtask

  task automatic set_box(int c, int r, int ta, int ba, int oc, int orw);
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_TEXT_ATTR, ta);
    write_reg(REG_BLANK_ATTR, ba);
    write_reg(REG_ORIGIN_COL, oc);
    write_reg(REG_ORIGIN_ROW, orw);
  endtask

  task automatic push_req(logic [1:0] f, logic [7:0] c, logic s, logic [11:0] i);
    term_req_t r;
    r.func = f;
    r.ch = c;
    r.srv = s;
    r.idx = i;
    pending_q.push_back(r);
  endtask

  // random request mix, weighted towards puts
  task automatic push_random(int n);
    int len, w;
    logic [7:0] c;
    logic [11:0] i;
    len = box_cols() * box_rows();
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      c = 8'($urandom);
      i = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, len + 3));
      if (w < 50)      push_req(FN_PUT, c, 1'($urandom), i);
      else if (w < 60) push_req(FN_PUT, CH_NEWLINE, 1'($urandom), i);
      else if (w < 67) push_req(FN_PUT, CH_RETURN, 1'($urandom), i);
      else if (w < 78) push_req(FN_PUT, CH_BACKSPACE, 1'($urandom), i);
      else if (w < 81) push_req(FN_PUT, CH_TAB, 1'($urandom), i);
      else if (w < 84) push_req(FN_CLEAR, c, 1'($urandom), i);
      else if (w < 98) push_req(FN_READ, c, 1'($urandom), i);
      else             push_req(2'd3, c, 1'($urandom), i);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || cursor_report_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    hold_asks = 0;
    cols_r = 80; rows_r = 25; tattr_r = 7; battr_r = 7; ocol_r = 0; orow_r = 0;
    for (int i = 0; i < DEPTH; i++) begin
      grid_char[i] = CH_NUL;
      grid_attr[i] = BLANK_ATTR_RST;
    end
    cursor_m = 0;
    mark_m = -1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry
    push_req(FN_READ, 8'h00, 1'b0, 12'd0);
    push_req(FN_READ, 8'hff, 1'b1, 12'hfff);
    push_req(FN_PUT, 8'h41, 1'b0, 12'd0);
    push_req(FN_PUT, 8'hff, 1'b1, 12'hfff);
    push_req(FN_PUT, 8'h00, 1'b1, 12'd0);
    push_req(FN_PUT, CH_BACKSPACE, 1'b1, 12'd0);
    push_req(FN_PUT, CH_BACKSPACE, 1'b0, 12'd0);
    push_req(FN_PUT, CH_TAB, 1'b0, 12'd0);
    push_req(FN_PUT, CH_NEWLINE, 1'b0, 12'd0);
    push_req(FN_PUT, CH_RETURN, 1'b1, 12'd0);
    push_req(FN_PUT, 8'h5a, 1'b1, 12'd0);
    push_req(FN_PUT, CH_BACKSPACE, 1'b1, 12'd0);
    push_req(FN_READ, 8'h00, 1'b0, 12'd1);
    push_req(FN_READ, 8'h00, 1'b0, 12'd80);
    push_req(FN_READ, 8'h00, 1'b0, 12'd1999);
    push_req(FN_READ, 8'h00, 1'b0, 12'd2000);
    push_req(2'd3, 8'h41, 1'b0, 12'h555);
    push_req(FN_CLEAR, 8'h00, 1'b0, 12'haaa);
    push_req(FN_READ, 8'h00, 1'b0, 12'd0);
    drain();

    // tiny box at far origin: scrolls often
    set_box(8, 4, 8'hff, 8'h00, 127, 127);
    push_random(120);
    hold_asks++;
    push_random(120);
    drain();
    set_box(1, 1, 8'h00, 8'hff, 0, 127);
    push_random(50);
    drain();
    // zero geometry is used as one
    set_box(0, 0, 8'h3c, 8'hc3, 127, 0);
    push_random(30);
    drain();
    // largest box, mostly without scrolling
    set_box(128, 32, $urandom_range(0, 255), $urandom_range(0, 255), 5, 9);
    for (int k = 0; k < 30; k++) push_req(FN_PUT, 8'($urandom), 1'($urandom), 12'($urandom));
    for (int k = 0; k < 6; k++) push_req(FN_READ, 8'h0, 1'b0, 12'($urandom));
    push_req(FN_READ, 8'h0, 1'b0, 12'hfff);
    push_req(FN_PUT, CH_NEWLINE, 1'b0, 12'd0);
    drain();
    // shrink without clearing: cursor left outside the box
    set_box(5, 3, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 127), $urandom_range(0, 127));
    push_req(FN_PUT, CH_BACKSPACE, 1'b0, 12'd0);
    push_req(FN_PUT, 8'h42, 1'b1, 12'd0);
    push_random(140);
    drain();
    // saturated geometry
    set_box(255, 63, $urandom_range(0, 255), $urandom_range(0, 255), 127, 127);
    push_random(25);
    push_req(FN_CLEAR, 8'h00, 1'b0, 12'd0);
    drain();
    set_box(16, 8, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 127), $urandom_range(0, 127));
    push_random(200);
    drain();
    set_box(3, 2, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 127), $urandom_range(0, 127));
    push_random(150);
    drain();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      cursor_report_q.push_back(terminal_step('{in_func, in_char_code, in_from_server,
                                                in_cell_index}));
      req_taken = 1'b1;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_func = '0;
    in_char_code = '0;
    in_from_server = 1'b0;
    in_cell_index = '0;
    req_taken = 1'b0;
    burst_left = 5;
    gap_left = 0;
  end

  always @(negedge clk) begin
    term_req_t r;
    if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        r = pending_q.pop_front();
        in_func <= r.func;
        in_char_code <= r.ch;
        in_from_server <= r.srv;
        in_cell_index <= r.idx;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern plus one long hold-off
  initial begin
    out_ready = 1'b0;
    hold_served = 0;
    hold_cnt = 0;
    stall_mode = 0;
    mode_left = 0;
  end

  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_cnt = LONG_HOLD;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    term_rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cursor_report_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = cursor_report_q.pop_front();
        if (out_cell_char !== e.cchar) report_mismatch("cell_char", out_cell_char, e.cchar);
        if (out_cell_attr !== e.cattr) report_mismatch("cell_attr", out_cell_attr, e.cattr);
        if (out_cursor_index !== e.cidx)
          report_mismatch("cursor_index", out_cursor_index, e.cidx);
        if (out_cursor_col !== e.ccol) report_mismatch("cursor_col", out_cursor_col, e.ccol);
        if (out_cursor_row !== e.crow) report_mismatch("cursor_row", out_cursor_row, e.crow);
        if (out_client_mark_out !== e.mark)
          report_mismatch("client_mark", out_client_mark_out, $signed(e.mark));
      end
    end
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

[files.f]
rtl/ttcb_pkg.sv
rtl/ttcb_div.sv
rtl/ttcb_dp.sv
rtl/ttcb_ctrl.sv
rtl/text_terminal_cell_buffer.sv
tb/sv/text_terminal_cell_buffer_test.sv
